FILE: rtl/core/sspq_pkg.sv
// Package for the stable sorted priority queue.
// Holds default sizes, status and operation codes, and the controller/datapath structs.
// Depends on nothing.
package sspq_pkg;

  localparam int unsigned QueueDepthDef   = 16;
  localparam int unsigned PriorityBitsDef = 8;
  localparam int unsigned TagBitsDef      = 16;

  typedef enum logic [1:0] {
    STAT_ENQUEUED = 2'd0,
    STAT_SERVED   = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_FULL     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  typedef struct packed {
    logic    load;
    logic    exec;
    op_e     op;
    status_e res;
  } dp_cmd_t;

  typedef struct packed {
    logic is_deq;
    logic full;
    logic empty;
  } dp_stat_t;

endpackage

FILE: rtl/core/sspq_ctrl.sv
// Controller of the stable sorted priority queue.
// Sequences capture and execution of one request; depends on sspq_pkg.
module sspq_ctrl
  import sspq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d   = state_q;
    cmd_o.load = 1'b0;
    cmd_o.exec = 1'b0;
    cmd_o.op   = OP_NONE;
    cmd_o.res  = STAT_ENQUEUED;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        if (stat_i.is_deq) begin
          if (stat_i.empty) begin
            cmd_o.res = STAT_EMPTY;
          end else begin
            cmd_o.op  = OP_REMOVE;
            cmd_o.res = STAT_SERVED;
          end
        end else begin
          if (stat_i.full) begin
            cmd_o.res = STAT_FULL;
          end else begin
            cmd_o.op  = OP_INSERT;
            cmd_o.res = STAT_ENQUEUED;
          end
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

endmodule

FILE: rtl/core/sspq_datapath.sv
// Datapath of the stable sorted priority queue.
// Holds the sorted row of cells, the request register and the result register;
// depends on sspq_pkg.
module sspq_datapath
  import sspq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH   = QueueDepthDef,
  parameter int unsigned PRIORITY_BITS = PriorityBitsDef,
  parameter int unsigned TAG_BITS      = TagBitsDef,
  localparam int unsigned CntW         = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dp_cmd_t                  cmd_i,
  output dp_stat_t                 stat_o,
  input  logic                     req_type_i,
  input  logic [PRIORITY_BITS-1:0] item_priority_i,
  input  logic [TAG_BITS-1:0]      item_tag_i,
  output logic                     done_o,
  output logic [1:0]               status_o,
  output logic [PRIORITY_BITS-1:0] served_priority_o,
  output logic [TAG_BITS-1:0]      served_tag_o,
  output logic [CntW-1:0]          occupancy_o
);

  logic                     req_deq_q;
  logic [PRIORITY_BITS-1:0] new_prio_q;
  logic [TAG_BITS-1:0]      new_tag_q;
  logic [CntW-1:0]          count_q, count_d;

  logic [PRIORITY_BITS-1:0] cell_prio_q [QUEUE_DEPTH];
  logic [TAG_BITS-1:0]      cell_tag_q  [QUEUE_DEPTH];
  logic [PRIORITY_BITS-1:0] ins_prio    [QUEUE_DEPTH];
  logic [TAG_BITS-1:0]      ins_tag     [QUEUE_DEPTH];
  logic [PRIORITY_BITS-1:0] rem_prio    [QUEUE_DEPTH];
  logic [TAG_BITS-1:0]      rem_tag     [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]   take;

  logic                     done_q;
  status_e                  status_q;
  logic [PRIORITY_BITS-1:0] sprio_q;
  logic [TAG_BITS-1:0]      stag_q;

  assign stat_o.is_deq = req_deq_q;
  assign stat_o.full   = (count_q == CntW'(QUEUE_DEPTH));
  assign stat_o.empty  = (count_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_deq_q  <= req_type_i;
      new_prio_q <= item_priority_i;
      new_tag_q  <= item_tag_i;
    end
  end

  // A cell takes part in the insertion when it is empty or holds a larger priority.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      take[i] = (count_q <= CntW'(i)) || (cell_prio_q[i] > new_prio_q);
    end
  end

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (i > 0 && take[i-1]) begin
        ins_prio[i] = cell_prio_q[i-1];
        ins_tag[i]  = cell_tag_q[i-1];
      end else if (take[i]) begin
        ins_prio[i] = new_prio_q;
        ins_tag[i]  = new_tag_q;
      end else begin
        ins_prio[i] = cell_prio_q[i];
        ins_tag[i]  = cell_tag_q[i];
      end
      if (i < QUEUE_DEPTH - 1) begin
        rem_prio[i] = cell_prio_q[i+1];
        rem_tag[i]  = cell_tag_q[i+1];
      end else begin
        rem_prio[i] = cell_prio_q[i];
        rem_tag[i]  = cell_tag_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (cmd_i.exec && cmd_i.op == OP_INSERT) begin
        cell_prio_q[i] <= ins_prio[i];
        cell_tag_q[i]  <= ins_tag[i];
      end else if (cmd_i.exec && cmd_i.op == OP_REMOVE) begin
        cell_prio_q[i] <= rem_prio[i];
        cell_tag_q[i]  <= rem_tag[i];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.exec) begin
      unique case (cmd_i.op)
        OP_INSERT: count_d = count_q + CntW'(1);
        OP_REMOVE: count_d = count_q - CntW'(1);
        default:   count_d = count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= cmd_i.exec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q <= cmd_i.res;
      if (cmd_i.op == OP_REMOVE) begin
        sprio_q <= cell_prio_q[0];
        stag_q  <= cell_tag_q[0];
      end else begin
        sprio_q <= '0;
        stag_q  <= '0;
      end
    end
  end

  assign done_o            = done_q;
  assign status_o          = status_q;
  assign served_priority_o = sprio_q;
  assign served_tag_o      = stag_q;
  assign occupancy_o       = count_q;

endmodule

FILE: rtl/core/stable_sorted_priority_queue_top.sv
// Top level of the stable sorted priority queue.
// Joins the controller and the datapath; depends on sspq_pkg, sspq_ctrl and sspq_datapath.
//
//   Channel   Handshake          Ports
//   request   start, busy        req_type_i, item_priority_i, item_tag_i
//   result    done_o (strobe)    status_o, served_priority_o, served_tag_o, occupancy_o
//
// A request is taken when start is high and busy is low. It is executed in the
// next cycle and its result is shown for one cycle after that. The next request
// may be taken while the result is shown. Reset empties the queue. The receiver
// cannot stall the result.
module stable_sorted_priority_queue_top
  import sspq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH   = QueueDepthDef,
  parameter int unsigned PRIORITY_BITS = PriorityBitsDef,
  parameter int unsigned TAG_BITS      = TagBitsDef,
  localparam int unsigned CntW         = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic                     req_type_i,
  input  logic [PRIORITY_BITS-1:0] item_priority_i,
  input  logic [TAG_BITS-1:0]      item_tag_i,
  output logic                     done_o,
  output logic [1:0]               status_o,
  output logic [PRIORITY_BITS-1:0] served_priority_o,
  output logic [TAG_BITS-1:0]      served_tag_o,
  output logic [CntW-1:0]          occupancy_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sspq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  sspq_datapath #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .PRIORITY_BITS (PRIORITY_BITS),
    .TAG_BITS      (TAG_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .req_type_i        (req_type_i),
    .item_priority_i   (item_priority_i),
    .item_tag_i        (item_tag_i),
    .done_o            (done_o),
    .status_o          (status_o),
    .served_priority_o (served_priority_o),
    .served_tag_o      (served_tag_o),
    .occupancy_o       (occupancy_o)
  );

endmodule

FILE: verif/stable_sorted_priority_queue_top_tb.sv
// Self-checking testbench for stable_sorted_priority_queue_top: a directed table,
// then about 500 random enqueue and dequeue requests with idle gaps on the sender.
// Depends on sspq_pkg and the RTL; each result is checked against the table or a predictor.
module stable_sorted_priority_queue_top_tb
  import sspq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH  = QueueDepthDef;
  localparam int unsigned PRIO_W = PriorityBitsDef;
  localparam int unsigned TAG_W  = TagBitsDef;
  localparam int unsigned OCC_W  = $clog2(DEPTH + 1);

  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  localparam int unsigned RAND_PER_PHASE = 167;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    status_e           status;
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
    logic [OCC_W-1:0]  occupancy;
  } queue_result_t;

  typedef struct packed {
    logic              req;
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
    logic              known;
    queue_result_t     res;
  } directed_row_t;

  typedef struct packed {
    logic          known;
    queue_result_t res;
  } fixed_answer_t;

  localparam int unsigned NUM_ROWS = 23;

  // Dequeues from the empty queue, fills the queue with ties at the head, the tail and in
  // the middle, then checks refusal when full and the serving order of the first dequeues.
  directed_row_t directed_tbl [NUM_ROWS] = '{
    '{REQ_DEQ, 8'hFF, 16'hFFFF, 1'b1, '{STAT_EMPTY,    8'h00, 16'h0000, 5'd0}},
    '{REQ_ENQ, 8'h00, 16'h0000, 1'b1, '{STAT_ENQUEUED, 8'h00, 16'h0000, 5'd1}},
    '{REQ_ENQ, 8'hFF, 16'hFFFF, 1'b1, '{STAT_ENQUEUED, 8'h00, 16'h0000, 5'd2}},
    '{REQ_ENQ, 8'h80, 16'h1001, 1'b1, '{STAT_ENQUEUED, 8'h00, 16'h0000, 5'd3}},
    '{REQ_ENQ, 8'h80, 16'h1002, 1'b1, '{STAT_ENQUEUED, 8'h00, 16'h0000, 5'd4}},
    '{REQ_ENQ, 8'h00, 16'h2001, 1'b1, '{STAT_ENQUEUED, 8'h00, 16'h0000, 5'd5}},
    '{REQ_ENQ, 8'hFF, 16'h3001, 1'b1, '{STAT_ENQUEUED, 8'h00, 16'h0000, 5'd6}},
    '{REQ_ENQ, 8'h80, 16'h1003, 1'b1, '{STAT_ENQUEUED, 8'h00, 16'h0000, 5'd7}},
    '{REQ_ENQ, 8'h7F, 16'h4001, 1'b1, '{STAT_ENQUEUED, 8'h00, 16'h0000, 5'd8}},
    '{REQ_ENQ, 8'h81, 16'h5001, 1'b1, '{STAT_ENQUEUED, 8'h00, 16'h0000, 5'd9}},
    '{REQ_ENQ, 8'h00, 16'h2002, 1'b1, '{STAT_ENQUEUED, 8'h00, 16'h0000, 5'd10}},
    '{REQ_ENQ, 8'h80, 16'h1004, 1'b1, '{STAT_ENQUEUED, 8'h00, 16'h0000, 5'd11}},
    '{REQ_ENQ, 8'hFF, 16'h3002, 1'b1, '{STAT_ENQUEUED, 8'h00, 16'h0000, 5'd12}},
    '{REQ_ENQ, 8'h7F, 16'h4002, 1'b1, '{STAT_ENQUEUED, 8'h00, 16'h0000, 5'd13}},
    '{REQ_ENQ, 8'h81, 16'h5002, 1'b1, '{STAT_ENQUEUED, 8'h00, 16'h0000, 5'd14}},
    '{REQ_ENQ, 8'h80, 16'h1005, 1'b1, '{STAT_ENQUEUED, 8'h00, 16'h0000, 5'd15}},
    '{REQ_ENQ, 8'h80, 16'h1006, 1'b1, '{STAT_ENQUEUED, 8'h00, 16'h0000, 5'd16}},
    '{REQ_ENQ, 8'h00, 16'hBEEF, 1'b1, '{STAT_FULL,     8'h00, 16'h0000, 5'd16}},
    '{REQ_DEQ, 8'h5A, 16'hA5A5, 1'b1, '{STAT_SERVED,   8'h00, 16'h0000, 5'd15}},
    '{REQ_DEQ, 8'hA5, 16'h5A5A, 1'b0, '0},
    '{REQ_DEQ, 8'h00, 16'h0000, 1'b0, '0},
    '{REQ_ENQ, 8'h00, 16'h2003, 1'b0, '0},
    '{REQ_DEQ, 8'hFF, 16'hFFFF, 1'b0, '0}
  };

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              req_type_i = REQ_ENQ;
  logic [PRIO_W-1:0] item_priority_i = '0;
  logic [TAG_W-1:0]  item_tag_i = '0;
  logic              busy;
  logic              done_o;
  logic [1:0]        status_o;
  logic [PRIO_W-1:0] served_priority_o;
  logic [TAG_W-1:0]  served_tag_o;
  logic [OCC_W-1:0]  occupancy_o;

  logic [PRIO_W-1:0] held_prio [DEPTH];
  logic [TAG_W-1:0]  held_tag [DEPTH];
  int                held_count = 0;

  queue_result_t pending_results [$];
  fixed_answer_t fixed_answer_q [$];

  int error_count = 0;
  int request_count = 0;
  int served_count = 0;
  int empty_count = 0;
  int full_count = 0;
  int idle_cycles = 0;
  int sender_idle_pct = 0;

  stable_sorted_priority_queue_top u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .req_type_i        (req_type_i),
    .item_priority_i   (item_priority_i),
    .item_tag_i        (item_tag_i),
    .done_o            (done_o),
    .status_o          (status_o),
    .served_priority_o (served_priority_o),
    .served_tag_o      (served_tag_o),
    .occupancy_o       (occupancy_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic queue_result_t apply_request(input logic rt, input logic [PRIO_W-1:0] p,
                                                  input logic [TAG_W-1:0] t);
    queue_result_t r;
    int pos;
    r = '0;
    if (rt == REQ_ENQ) begin
      if (held_count >= DEPTH) begin
        r.status = STAT_FULL;
      end else begin
        pos = 0;
        while (pos < held_count && held_prio[pos] <= p) pos++;
        for (int k = held_count; k > pos; k--) begin
          held_prio[k] = held_prio[k-1];
          held_tag[k]  = held_tag[k-1];
        end
        held_prio[pos] = p;
        held_tag[pos]  = t;
        held_count++;
        r.status = STAT_ENQUEUED;
      end
    end else begin
      if (held_count == 0) begin
        r.status = STAT_EMPTY;
      end else begin
        r.status = STAT_SERVED;
        r.prio   = held_prio[0];
        r.tag    = held_tag[0];
        for (int k = 1; k < held_count; k++) begin
          held_prio[k-1] = held_prio[k];
          held_tag[k-1]  = held_tag[k];
        end
        held_count--;
      end
    end
    r.occupancy = OCC_W'(held_count);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  task automatic issue_request(input logic rt, input logic [PRIO_W-1:0] p,
                               input logic [TAG_W-1:0] t, input fixed_answer_t answer);
    int gap;
    gap = ($urandom_range(0, 99) < sender_idle_pct) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    fixed_answer_q.push_back(answer);
    start           <= 1'b1;
    req_type_i      <= rt;
    item_priority_i <= p;
    item_tag_i      <= t;
    do @(posedge clk_i); while (busy);
  endtask

  always @(posedge clk_i) begin
    queue_result_t want;
    queue_result_t predicted;
    fixed_answer_t answer;
    if (rst_ni) begin
      if (done_o || (start && !busy)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (done_o) begin
        case (status_o)
          STAT_SERVED: served_count++;
          STAT_EMPTY:  empty_count++;
          STAT_FULL:   full_count++;
          default:     ;
        endcase
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result status", status_o, 0);
        end else begin
          want = pending_results.pop_front();
          if (status_o != want.status) report_mismatch("status", status_o, want.status);
          if (served_priority_o != want.prio)
            report_mismatch("served_priority", served_priority_o, want.prio);
          if (served_tag_o != want.tag) report_mismatch("served_tag", served_tag_o, want.tag);
          if (occupancy_o != want.occupancy)
            report_mismatch("occupancy", occupancy_o, want.occupancy);
        end
      end
      if (start && !busy) begin
        request_count++;
        predicted = apply_request(req_type_i, item_priority_i, item_tag_i);
        answer = (fixed_answer_q.size() > 0) ? fixed_answer_q.pop_front() : '0;
        pending_results.push_back(answer.known ? answer.res : predicted);
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog expired with %0d results outstanding", $time,
                 pending_results.size());
        $display("stable_sorted_priority_queue_top regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int mode;
    int enq_pct;
    logic rt;
    logic [PRIO_W-1:0] p;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    sender_idle_pct = 22;
    foreach (directed_tbl[i]) begin
      issue_request(directed_tbl[i].req, directed_tbl[i].prio, directed_tbl[i].tag,
                    '{directed_tbl[i].known, directed_tbl[i].res});
    end

    mode = 0;
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 61 : 0;
      start <= 1'b0;
      do @(posedge clk_i); while (pending_results.size() > 0);
      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        if (i % 24 == 0) mode = $urandom_range(0, 2);
        enq_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
        rt = ($urandom_range(0, 99) < enq_pct) ? REQ_ENQ : REQ_DEQ;
        p = ($urandom_range(0, 99) < 40) ? PRIO_W'($urandom_range(0, 3)) : PRIO_W'($urandom);
        issue_request(rt, p, TAG_W'($urandom), '0);
      end
    end

    start <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() > 0);
    repeat (8) @(posedge clk_i);
    if (pending_results.size() > 0)
      report_mismatch("results never delivered", pending_results.size(), 0);

    $display("Ran %0d requests (%0d from the directed table) with ties, overflow and underflow.",
             request_count, NUM_ROWS);
    $display("Results seen: %0d served, %0d empty, %0d refused as full; %0d mismatches.",
             served_count, empty_count, full_count, error_count);
    if (error_count == 0) begin
      $display("stable_sorted_priority_queue_top regression: pass");
    end else begin
      $display("stable_sorted_priority_queue_top regression: fail");
    end
    $finish;
  end

endmodule
